FILE: sv/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, masked while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/fntc_pkg.sv
package fntc_pkg;

    localparam int FREQ_FRAC_BITS = 8;

    localparam int FREQ_W = 24;
    localparam int NOTE_IN_W = 7;
    localparam int NOTE_W = 9;
    localparam int CENTS_W = 19;

    // log2 in Q.30: 5 integer bits (msb index up to 23), 30 fraction bits
    localparam int LFRAC = 30;
    localparam int P_W = 5;
    localparam int LOG_W = P_W + LFRAC;
    localparam int MANT_W = LFRAC + 1;

    localparam logic signed [NOTE_W-1:0] NOTE_NONE = -9'sd1;
    localparam logic signed [NOTE_W-1:0] NOTE_LO = -9'sd132;
    localparam logic signed [NOTE_W-1:0] NOTE_HI = 9'sd156;

    // sideband carried alongside the log2 pipeline
    typedef struct packed {
        logic                 zero;
        logic [NOTE_IN_W-1:0] target_note;
    } t_side;

    // index of highest set bit of a byte (0 when empty)
    function automatic logic [2:0] msb8(input logic [7:0] b);
        logic [2:0] idx;
        idx = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // Bit-exact log2 by repeated squaring; elaboration use only.
    function automatic logic [LOG_W-1:0] log2_q30(input logic [63:0] x);
        logic [63:0]      m;
        logic [LFRAC-1:0] frac;
        int               p;
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                p = i;
            end
        end
        if (p <= LFRAC) begin
            m = x << (LFRAC - p);
        end else begin
            m = x >> (p - LFRAC);
        end
        frac = '0;
        for (int i = 0; i < LFRAC; i++) begin
            m = (m * m) >> LFRAC;
            frac = frac << 1;
            if (m >= (64'd1 << (LFRAC + 1))) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return {P_W'(p), frac};
    endfunction

    // log2 of 440 Hz at the input's fixed-point scale
    localparam logic [LOG_W-1:0] LOG_REF = log2_q30(64'd440 << FREQ_FRAC_BITS);

endpackage

FILE: sv/fntc_log2.sv
// Pipelined log2, one fraction bit per squaring stage.
module fntc_log2 import fntc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [FREQ_W-1:0] i_x,
    input  t_side             i_side,
    output logic              o_vld,
    output logic [LOG_W-1:0]  o_log,
    output t_side             o_side
);

    // stage A: msb index
    logic [P_W-1:0]    n_pa;
    logic              r_va;
    logic [P_W-1:0]    r_pa;
    logic [FREQ_W-1:0] r_xa;
    t_side             r_sa;

    always_comb begin
        priority if (i_x[23:16] != 8'd0) begin
            n_pa = P_W'(16) + {2'b00, msb8(i_x[23:16])};
        end else if (i_x[15:8] != 8'd0) begin
            n_pa = P_W'(8) + {2'b00, msb8(i_x[15:8])};
        end else begin
            n_pa = {2'b00, msb8(i_x[7:0])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa <= n_pa;
        r_xa <= i_x;
        r_sa <= i_side;
    end

    // stage B onwards: normalised mantissa in Q1.30, then squaring stages
    logic              r_v [0:LFRAC];
    logic [MANT_W-1:0] r_m [0:LFRAC];
    logic [LFRAC-1:0]  r_f [0:LFRAC];
    logic [P_W-1:0]    r_p [0:LFRAC];
    t_side             r_s [0:LFRAC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m[0] <= MANT_W'(r_xa) << (P_W'(LFRAC) - r_pa);
        r_f[0] <= '0;
        r_p[0] <= r_pa;
        r_s[0] <= r_sa;
    end

    for (genvar g = 0; g < LFRAC; g++) begin : g_sq
        logic [2*MANT_W-1:0] n_sq;
        logic [MANT_W:0]     n_t;

        assign n_sq = r_m[g] * r_m[g];
        assign n_t  = n_sq[2*MANT_W-1:LFRAC];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
        end

        // square >= 2.0 yields a one bit and a halving
        always_ff @(posedge i_clk) begin
            r_m[g+1] <= n_t[MANT_W] ? n_t[MANT_W:1] : n_t[MANT_W-1:0];
            r_f[g+1] <= {r_f[g][LFRAC-2:0], n_t[MANT_W]};
            r_p[g+1] <= r_p[g];
            r_s[g+1] <= r_s[g];
        end
    end

    assign o_vld  = r_v[LFRAC];
    assign o_log  = {r_p[LFRAC], r_f[LFRAC]};
    assign o_side = r_s[LFRAC];

endmodule

FILE: sv/frequency_to_note_and_cents_core.sv
// Tuner arithmetic core. Takes a frequency (unsigned, Hz x 2^8) and a target
// MIDI note per request and returns the nearest MIDI note, a valid flag and the
// offset from the target's ideal pitch in tenths of a cent (saturated to
// 19 bits). A request is taken whenever start is high and busy is low; busy
// is only high during reset, so one request per cycle is sustained. Each
// result appears for one cycle, flagged by
// o_strobe, in request order; the receiver cannot stall and must take it then.
// The pipeline is the log2 block's two normalisation stages plus 30
// squaring stages (one 31x31 multiply each, one fraction bit per stage),
// followed by four stages of scaling, rounding and saturation.
// A zero frequency gives o_note_valid low, note -1 and offset 0.

`include "assert_macros.svh"

module frequency_to_note_and_cents_core import fntc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [FREQ_W-1:0]         i_frequency,
    input  logic [NOTE_IN_W-1:0]      i_target_note,
    output logic                      o_strobe,
    output logic                      o_note_valid,
    output logic signed [NOTE_W-1:0]  o_nearest_note,
    output logic signed [CENTS_W-1:0] o_cents_offset
);

    // widths of the scaling datapath
    localparam int D_W  = LOG_W + 1;        // log2(f/440), Q.30 signed
    localparam int NV_W = 41;               // 69 + 12*d, Q.30
    localparam int CV_W = 50;               // 12000*d, Q.30
    localparam int NR_W = NV_W - LFRAC;     // rounded note
    localparam int CR_W = CV_W - LFRAC;     // rounded cents
    localparam int TO_W = 8;                // target - 69
    localparam int TK_W = 18;               // 1000*(target - 69)
    localparam int CS_W = CR_W + 1;         // cents before saturation

    localparam logic signed [NV_W-1:0] NOTE_BASE = NV_W'(69) << LFRAC;
    localparam logic signed [NV_W-1:0] NOTE_SCALE = NV_W'(12);
    localparam logic signed [CV_W-1:0] CENTS_SCALE = CV_W'(12000);
    localparam logic signed [TK_W-1:0] TGT_SCALE = TK_W'(1000);
    localparam logic signed [TO_W-1:0] NOTE_A4 = TO_W'(69);
    localparam logic signed [NV_W-1:0] HALF_NV = NV_W'(1) << (LFRAC - 1);
    localparam logic signed [CV_W-1:0] HALF_CV = CV_W'(1) << (LFRAC - 1);
    localparam logic signed [CS_W-1:0] CENTS_HI = CS_W'(262143);
    localparam logic signed [CS_W-1:0] CENTS_LO = -CS_W'(262144);
    localparam logic signed [NR_W-1:0] NOTE_SAT_HI = NR_W'(255);
    localparam logic signed [NR_W-1:0] NOTE_SAT_LO = -NR_W'(256);

    // no back-pressure: only reset holds requests off
    assign busy = !i_rst_n;

    // log2 pipeline
    t_side             n_side;
    logic              w_lvld;
    logic [LOG_W-1:0]  w_log;
    t_side             w_lside;

    assign n_side.zero        = (i_frequency == '0);
    assign n_side.target_note = i_target_note;

    fntc_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_x     (i_frequency),
        .i_side  (n_side),
        .o_vld   (w_lvld),
        .o_log   (w_log),
        .o_side  (w_lside)
    );

    // E1: subtract log2 of 440 Hz; offset target from A4
    logic                   r_v1, r_z1;
    logic signed [D_W-1:0]  r_d;
    logic signed [TO_W-1:0] r_toff;

    // E2: constant scaling
    logic                   r_v2, r_z2;
    logic signed [NV_W-1:0] r_nv;
    logic signed [CV_W-1:0] r_cv;
    logic signed [TK_W-1:0] r_tk2;

    // E3: round half away from zero, i.e. floor(v + half - sign)
    logic                   r_v3, r_z3;
    logic signed [NV_W-1:0] n_nsum;
    logic signed [CV_W-1:0] n_csum;
    logic signed [NR_W-1:0] r_nr;
    logic signed [CR_W-1:0] r_cr;
    logic signed [TK_W-1:0] r_tk3;

    // E4: target offset, saturation, invalid override
    logic signed [CS_W-1:0]    n_c;
    logic signed [CENTS_W-1:0] n_cents;
    logic signed [NOTE_W-1:0]  n_note;
    logic                      r_strobe;
    logic                      r_note_valid;
    logic signed [NOTE_W-1:0]  r_nearest_note;
    logic signed [CENTS_W-1:0] r_cents_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= w_lvld;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_strobe <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z1   <= w_lside.zero;
        r_d    <= $signed({1'b0, w_log}) - $signed({1'b0, LOG_REF});
        r_toff <= $signed({1'b0, w_lside.target_note}) - NOTE_A4;
    end

    always_ff @(posedge i_clk) begin
        r_z2  <= r_z1;
        r_nv  <= NOTE_BASE + NV_W'(r_d) * NOTE_SCALE;
        r_cv  <= CV_W'(r_d) * CENTS_SCALE;
        r_tk2 <= TK_W'(r_toff) * TGT_SCALE;
    end

    assign n_nsum = r_nv + HALF_NV - $signed({{(NV_W-1){1'b0}}, r_nv[NV_W-1]});
    assign n_csum = r_cv + HALF_CV - $signed({{(CV_W-1){1'b0}}, r_cv[CV_W-1]});

    always_ff @(posedge i_clk) begin
        r_z3  <= r_z2;
        r_nr  <= n_nsum[NV_W-1:LFRAC];
        r_cr  <= n_csum[CV_W-1:LFRAC];
        r_tk3 <= r_tk2;
    end

    assign n_c = CS_W'(r_cr) - CS_W'(r_tk3);

    always_comb begin
        priority if (r_z3) begin
            n_cents = '0;
        end else if (n_c > CENTS_HI) begin
            n_cents = CENTS_W'(CENTS_HI);
        end else if (n_c < CENTS_LO) begin
            n_cents = CENTS_W'(CENTS_LO);
        end else begin
            n_cents = n_c[CENTS_W-1:0];
        end

        priority if (r_z3) begin
            n_note = NOTE_NONE;
        end else if (r_nr > NOTE_SAT_HI) begin
            n_note = NOTE_W'(NOTE_SAT_HI);
        end else if (r_nr < NOTE_SAT_LO) begin
            n_note = NOTE_W'(NOTE_SAT_LO);
        end else begin
            n_note = r_nr[NOTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_note_valid   <= !r_z3;
        r_nearest_note <= n_note;
        r_cents_offset <= n_cents;
    end

    assign o_strobe       = r_strobe;
    assign o_note_valid   = r_note_valid;
    assign o_nearest_note = r_nearest_note;
    assign o_cents_offset = r_cents_offset;

    // invalid results carry the fixed fill values
    `ASSERT_IMPL(a_invalid_fill, i_clk, i_rst_n, o_strobe && !o_note_valid,
                 o_nearest_note == NOTE_NONE && o_cents_offset == '0)
    // a valid note stays within the reachable MIDI range
    `ASSERT_IMPL(a_note_range, i_clk, i_rst_n, o_strobe && o_note_valid,
                 o_nearest_note >= NOTE_LO && o_nearest_note <= NOTE_HI)
    // the rounding stage always hands over to the output register
    `ASSERT_NEXT(a_last_stage, i_clk, i_rst_n, r_v3, o_strobe)

endmodule
